### design/ipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types and constants of the isolated point filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int COORD_W = 16;
  localparam int THR_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_HEIGHT_LOW  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_HIGH = 2'd1;
  localparam logic [1:0] REG_SIZE_SQ     = 2'd2;
  localparam logic [1:0] REG_CLEAR_SQ    = 2'd3;

  localparam logic signed [COORD_W-1:0] HEIGHT_LOW_RST  = -16'sd35;
  localparam logic signed [COORD_W-1:0] HEIGHT_HIGH_RST = 16'sd35;
  localparam logic [THR_W-1:0]          SIZE_SQ_RST     = 32'd3600;
  localparam logic [THR_W-1:0]          CLEAR_SQ_RST    = 32'd10000;

  typedef struct packed {
    logic signed [COORD_W-1:0] height_low;
    logic signed [COORD_W-1:0] height_high;
    logic [THR_W-1:0]          size_sq;
    logic [THR_W-1:0]          clear_sq;
  } cfg_t;

  typedef struct packed {
    logic prime;   // load probe from home, clear reject flag
    logic cmp_en;  // compare home against current probe
    logic shift;   // move home point one cell toward the head
  } cell_ctl_t;

endpackage

### design/ipf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_cfg
// APB-style register bank holding height limits and distance thresholds.
// ----------------------------------------------------------------------------
module ipf_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ipf_pkg::ADDR_W-1:0] paddr,
  input  logic [ipf_pkg::DATA_W-1:0] pwdata,
  output logic [ipf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ipf_pkg::cfg_t              cfg
);
  import ipf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height_low  <= HEIGHT_LOW_RST;
      cfg.height_high <= HEIGHT_HIGH_RST;
      cfg.size_sq     <= SIZE_SQ_RST;
      cfg.clear_sq    <= CLEAR_SQ_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HEIGHT_LOW:  cfg.height_low  <= pwdata[COORD_W-1:0];
        REG_HEIGHT_HIGH: cfg.height_high <= pwdata[COORD_W-1:0];
        REG_SIZE_SQ:     cfg.size_sq     <= pwdata;
        REG_CLEAR_SQ:    cfg.clear_sq    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEIGHT_LOW:  prdata = DATA_W'(cfg.height_low);
      REG_HEIGHT_HIGH: prdata = DATA_W'(cfg.height_high);
      REG_SIZE_SQ:     prdata = cfg.size_sq;
      REG_CLEAR_SQ:    prdata = cfg.clear_sq;
      default:         prdata = '0;
    endcase
  end

endmodule

### design/ipf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_cell
// One storage cell: holds a point, compares it against a probe that rotates
// around the ring, and shifts its point toward the head while draining.
// ----------------------------------------------------------------------------
module ipf_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  ipf_pkg::cell_ctl_t                 ctl,
  input  logic [ipf_pkg::THR_W-1:0]          size_sq,
  input  logic [ipf_pkg::THR_W-1:0]          clear_sq,
  input  logic                               we,
  input  logic signed [ipf_pkg::COORD_W-1:0] wr_x,
  input  logic signed [ipf_pkg::COORD_W-1:0] wr_y,
  input  logic signed [ipf_pkg::COORD_W-1:0] wr_z,
  input  logic                               home_valid,
  input  logic signed [ipf_pkg::COORD_W-1:0] shift_x,
  input  logic signed [ipf_pkg::COORD_W-1:0] shift_y,
  input  logic signed [ipf_pkg::COORD_W-1:0] shift_z,
  input  logic                               shift_rej,
  input  logic signed [ipf_pkg::COORD_W-1:0] probe_in_x,
  input  logic signed [ipf_pkg::COORD_W-1:0] probe_in_y,
  input  logic                               probe_in_valid,
  output logic signed [ipf_pkg::COORD_W-1:0] home_x,
  output logic signed [ipf_pkg::COORD_W-1:0] home_y,
  output logic signed [ipf_pkg::COORD_W-1:0] home_z,
  output logic                               rej,
  output logic signed [ipf_pkg::COORD_W-1:0] probe_x,
  output logic signed [ipf_pkg::COORD_W-1:0] probe_y,
  output logic                               probe_valid
);
  import ipf_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] dx_sq;
  logic signed [2*COORD_W+1:0] dy_sq;
  logic [THR_W-1:0]            sq_x;
  logic [THR_W-1:0]            sq_y;
  logic                        sq_valid;
  logic [THR_W:0]              pair_dist;
  logic                        hit;

  assign dx    = $signed({home_x[COORD_W-1], home_x}) - $signed({probe_x[COORD_W-1], probe_x});
  assign dy    = $signed({home_y[COORD_W-1], home_y}) - $signed({probe_y[COORD_W-1], probe_y});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  // a difference of 17 bits squares to less than 2^32
  assign pair_dist = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit       = sq_valid && (pair_dist > {1'b0, size_sq})
                     && (pair_dist < {1'b0, clear_sq});

  always_ff @(posedge clk) begin
    if (we) begin
      home_x <= wr_x;
      home_y <= wr_y;
      home_z <= wr_z;
    end else if (ctl.shift) begin
      home_x <= shift_x;
      home_y <= shift_y;
      home_z <= shift_z;
    end
    if (ctl.prime) begin
      probe_x <= home_x;
      probe_y <= home_y;
    end else begin
      probe_x <= probe_in_x;
      probe_y <= probe_in_y;
    end
    sq_x <= dx_sq[THR_W-1:0];
    sq_y <= dy_sq[THR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_valid <= 1'b0;
      sq_valid    <= 1'b0;
      rej         <= 1'b0;
    end else begin
      probe_valid <= ctl.prime ? home_valid : probe_in_valid;
      sq_valid    <= ctl.cmp_en & home_valid & probe_valid;
      if (ctl.prime) begin
        rej <= 1'b0;
      end else if (ctl.shift) begin
        rej <= shift_rej;
      end else if (hit) begin
        rej <= 1'b1;
      end
    end
  end

endmodule

### design/isolated_point_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_point_filter
// Height/forward pass filter with a pairwise isolation check over a ring of
// point cells; kept points leave in arrival order at frame end.
// ----------------------------------------------------------------------------
// points are accepted while in S_LOAD; pt_stall is high in every other state
// frame end: its accept, a prime step, the ring compare, the drain of each
//   stored point plus a step to leave the drain, then the flush
// the ring compare moves the probes one hop per cycle
// result stalls hold the drain and the flush
// reset clears point count, drop flag, output valid and registers to defaults
module isolated_point_filter #(
  parameter int MAX_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ipf_pkg::ADDR_W-1:0]         paddr,
  input  logic [ipf_pkg::DATA_W-1:0]         pwdata,
  output logic [ipf_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               pt_valid,
  output logic                               pt_stall,
  input  logic signed [ipf_pkg::COORD_W-1:0] point_x,
  input  logic signed [ipf_pkg::COORD_W-1:0] point_y,
  input  logic signed [ipf_pkg::COORD_W-1:0] point_z,
  input  logic                               frame_end,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [ipf_pkg::COORD_W-1:0] kept_x,
  output logic signed [ipf_pkg::COORD_W-1:0] kept_y,
  output logic signed [ipf_pkg::COORD_W-1:0] kept_z,
  output logic                               kept_valid,
  output logic                               run_last,
  output logic                               dropped
);
  import ipf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int STEP_W = $clog2(MAX_POINTS + 2);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_PRIME = 5'b00010,
    S_CHECK = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t              state;
  cfg_t                cfg;
  cell_ctl_t           ctl;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic                overflow;
  logic                pt_acc;
  logic                pass;
  logic                full;
  logic                out_free;
  logic                emit;
  logic                drain_move;

  logic signed [COORD_W-1:0] pend_x;
  logic signed [COORD_W-1:0] pend_y;
  logic signed [COORD_W-1:0] pend_z;
  logic                      pend_valid;

  logic signed [COORD_W-1:0] cx [MAX_POINTS];
  logic signed [COORD_W-1:0] cy [MAX_POINTS];
  logic signed [COORD_W-1:0] cz [MAX_POINTS];
  logic                      crej [MAX_POINTS];
  logic signed [COORD_W-1:0] px [MAX_POINTS];
  logic signed [COORD_W-1:0] py [MAX_POINTS];
  logic                      pv [MAX_POINTS];

  ipf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign pt_stall = (state != S_LOAD);
  assign pt_acc   = pt_valid & ~pt_stall;
  assign pass     = (point_z > cfg.height_low) && (point_z < cfg.height_high)
                    && (point_x > 0);
  assign full     = (count == CNT_W'(MAX_POINTS));
  assign out_free = ~res_valid | ~res_stall;

  // drain: rejected heads are skipped, a kept head waits for the pending slot; flush emits once output is free
  always_comb begin
    drain_move = 1'b0;
    emit       = 1'b0;
    if (state == S_DRAIN && rem != '0) begin
      if (crej[0] || !pend_valid) begin
        drain_move = 1'b1;
      end else if (out_free) begin
        drain_move = 1'b1;
        emit       = 1'b1;
      end
    end else if (state == S_FLUSH && out_free) begin
      emit = 1'b1;
    end
  end

  assign ctl.prime  = (state == S_PRIME);
  assign ctl.cmp_en = (state == S_CHECK) && (step < STEP_W'(MAX_POINTS));
  assign ctl.shift  = drain_move;

  generate
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      logic signed [COORD_W-1:0] sh_x;
      logic signed [COORD_W-1:0] sh_y;
      logic signed [COORD_W-1:0] sh_z;
      logic                      sh_rej;
      logic                      we;
      logic                      hv;

      if (k < MAX_POINTS - 1) begin : g_mid
        assign sh_x   = cx[k+1];
        assign sh_y   = cy[k+1];
        assign sh_z   = cz[k+1];
        assign sh_rej = crej[k+1];
      end else begin : g_tail
        assign sh_x   = '0;
        assign sh_y   = '0;
        assign sh_z   = '0;
        assign sh_rej = 1'b0;
      end

      assign we = pt_acc & pass & (count == CNT_W'(k));
      assign hv = (count > CNT_W'(k));

      ipf_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .ctl            (ctl),
        .size_sq        (cfg.size_sq),
        .clear_sq       (cfg.clear_sq),
        .we             (we),
        .wr_x           (point_x),
        .wr_y           (point_y),
        .wr_z           (point_z),
        .home_valid     (hv),
        .shift_x        (sh_x),
        .shift_y        (sh_y),
        .shift_z        (sh_z),
        .shift_rej      (sh_rej),
        .probe_in_x     (px[(k + MAX_POINTS - 1) % MAX_POINTS]),
        .probe_in_y     (py[(k + MAX_POINTS - 1) % MAX_POINTS]),
        .probe_in_valid (pv[(k + MAX_POINTS - 1) % MAX_POINTS]),
        .home_x         (cx[k]),
        .home_y         (cy[k]),
        .home_z         (cz[k]),
        .rej            (crej[k]),
        .probe_x        (px[k]),
        .probe_y        (py[k]),
        .probe_valid    (pv[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      step       <= '0;
      rem        <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (pt_acc) begin
            if (pass && !full) begin
              count <= count + 1'b1;
            end else if (pass) begin
              overflow <= 1'b1;
            end
            if (frame_end) begin
              state <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          step  <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          step <= step + 1'b1;
          // the extra steps past MAX_POINTS let the last compares leave the cell pipeline
          if (step == STEP_W'(MAX_POINTS + 1)) begin
            rem   <= count;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (rem == '0) begin
            state <= S_FLUSH;
          end else if (drain_move) begin
            rem <= rem - 1'b1;
            if (!crej[0]) begin
              pend_valid <= 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            count      <= '0;
            overflow   <= 1'b0;
            state      <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (drain_move && !crej[0]) begin
      pend_x <= cx[0];
      pend_y <= cy[0];
      pend_z <= cz[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == S_FLUSH && !pend_valid) begin
        kept_x     <= '0;
        kept_y     <= '0;
        kept_z     <= '0;
        kept_valid <= 1'b0;
      end else begin
        kept_x     <= pend_x;
        kept_y     <= pend_y;
        kept_z     <= pend_z;
        kept_valid <= 1'b1;
      end
      run_last <= (state == S_FLUSH);
      dropped  <= overflow;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("stored point count beyond capacity");

  a_flush_emits_last : assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (res_valid && run_last && count == '0))
    else $error("flush did not deliver the closing item");

  a_empty_only_last : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !kept_valid) |-> run_last)
    else $error("empty item that does not close the frame");

endmodule
